[rtl/core/ucpl_pkg.sv]
// Shared types and constants for the serial command and parameter loader.
// Used by the loader core and its port checker; depends on nothing else.
`default_nettype none

package ucpl_pkg;

    // Default number of 32-bit parameter slots in one frame
    localparam int PARAM_SLOTS_DEF = 14;

    // Width of the result kind carried on tuser
    localparam int EVENT_W = 3;

    // Result kinds
    typedef enum logic [EVENT_W-1:0] {
        EV_ABSORB  = 3'd0,
        EV_WRITE   = 3'd1,
        EV_DROP    = 3'd2,
        EV_CMD     = 3'd3,
        EV_UNKNOWN = 3'd4
    } t_event;

    // Command bytes accepted while no frame is open
    localparam logic [7:0] CMD_TOGGLE_A = 8'h30;
    localparam logic [7:0] CMD_TOGGLE_B = 8'h31;
    localparam logic [7:0] CMD_READBACK = 8'h32;
    localparam logic [7:0] CMD_FRAME    = 8'h33;
    localparam logic [7:0] CMD_SAVE     = 8'h34;

    // Byte that must follow the frame payload
    localparam logic [7:0] TRAILER = 8'hAB;

endpackage

`default_nettype wire

[rtl/core/uart_command_parameter_loader.sv]
// Serial command decoder and parameter frame loader (top level); depends on ucpl_pkg.
// A command, absorbed byte or dropped frame gives one registered result in the cycle after
// its input transaction; these bytes are taken one per cycle while the sequencer is idle
// and no result is stalled. A committed frame gives PARAM_SLOTS writes; each takes four
// byte reads on the single buffer read port (read, shift), then an emit held by stalls.
// Reset (synchronous, active low) clears sequencer, frame state, toggle and output valid.
`default_nettype none

module uart_command_parameter_loader #(
    parameter int PARAM_SLOTS = ucpl_pkg::PARAM_SLOTS_DEF,
    localparam int IW         = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1,
    localparam int TD_BITS    = IW + 35,
    localparam int TD_W       = ((TD_BITS + 7) / 8) * 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // slave side: tdata = rx_byte[7:0]
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,
    // master side: tdata = param_index, param_word[31:0], stream_enable,
    // readback_request, beep_request, zero fill
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [TD_W-1:0]              m_axis_tdata,
    // tuser = event_res[2:0]
    output logic [ucpl_pkg::EVENT_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast
);

    localparam int FRAME_BYTES = 4 * PARAM_SLOTS;
    localparam int AW          = IW + 2;
    localparam int CW          = $clog2(FRAME_BYTES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_SH,
        S_EMIT
    } t_state;

    // Sequencer and frame state
    t_state          r_state, n_state;
    logic            r_active, n_active;
    logic [CW-1:0]   r_count, n_count;
    logic            r_toggle, n_toggle;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [IW-1:0]   r_slot, n_slot;
    logic [31:0]     r_word, n_word;

    // Output register
    logic             r_ovalid, n_ovalid;
    ucpl_pkg::t_event r_oev, n_oev;
    logic [IW-1:0]    r_oidx, n_oidx;
    logic [31:0]      r_oword, n_oword;
    logic             r_olast, n_olast;
    logic             r_ose, n_ose;
    logic             r_orb, n_orb;
    logic             r_obp, n_obp;

    // Frame buffer
    logic [7:0]      r_mem [FRAME_BYTES];
    logic [7:0]      r_mem_q;
    logic            mem_we;

    logic            out_free;
    logic            in_take;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign mem_we        = in_take && r_active && (r_count < CW'(FRAME_BYTES));

    // Write incoming frame bytes, register one read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        r_mem_q <= r_mem[r_rd_addr];
    end

    // Next-state logic for the sequencer and output register
    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_count   = r_count;
        n_toggle  = r_toggle;
        n_rd_addr = r_rd_addr;
        n_slot    = r_slot;
        n_word    = r_word;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_oev     = r_oev;
        n_oidx    = r_oidx;
        n_oword   = r_oword;
        n_olast   = r_olast;
        n_ose     = r_ose;
        n_orb     = r_orb;
        n_obp     = r_obp;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    // default single result
                    n_ovalid = 1'b1;
                    n_oidx   = '0;
                    n_oword  = '0;
                    n_olast  = 1'b1;
                    n_orb    = 1'b0;
                    n_obp    = 1'b0;
                    n_oev    = ucpl_pkg::EV_ABSORB;
                    if (r_active) begin
                        if (r_count < CW'(FRAME_BYTES)) begin
                            n_count = r_count + CW'(1);
                        end else begin
                            n_count  = '0;
                            n_active = 1'b0;
                            if (s_axis_tdata != ucpl_pkg::TRAILER) begin
                                n_oev = ucpl_pkg::EV_DROP;
                            end else begin
                                // start replay of the buffered frame
                                n_ovalid  = r_ovalid && !m_axis_tready;
                                n_oev     = r_oev;
                                n_oidx    = r_oidx;
                                n_oword   = r_oword;
                                n_olast   = r_olast;
                                n_orb     = r_orb;
                                n_obp     = r_obp;
                                n_rd_addr = '0;
                                n_slot    = '0;
                                n_state   = S_RD;
                            end
                        end
                    end else begin
                        n_obp = 1'b1;
                        n_oev = ucpl_pkg::EV_CMD;
                        case (s_axis_tdata)
                            ucpl_pkg::CMD_TOGGLE_A,
                            ucpl_pkg::CMD_TOGGLE_B: n_toggle = !r_toggle;
                            ucpl_pkg::CMD_READBACK: n_orb = 1'b1;
                            ucpl_pkg::CMD_FRAME: begin
                                n_active = 1'b1;
                                n_count  = '0;
                            end
                            ucpl_pkg::CMD_SAVE: n_oev = ucpl_pkg::EV_CMD;
                            default: n_oev = ucpl_pkg::EV_UNKNOWN;
                        endcase
                    end
                    n_ose = n_toggle;
                end
            end
            S_RD: begin
                // issue one byte read
                n_rd_addr = r_rd_addr + AW'(1);
                n_state   = S_SH;
            end
            S_SH: begin
                // shift the byte in, least significant first
                n_word = {r_mem_q, r_word[31:8]};
                if (r_rd_addr[1:0] == 2'b00) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                // hand the assembled word to the output register
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oev    = ucpl_pkg::EV_WRITE;
                    n_oidx   = r_slot;
                    n_oword  = r_word;
                    n_olast  = (r_slot == IW'(PARAM_SLOTS - 1));
                    n_orb    = (r_slot == IW'(PARAM_SLOTS - 1));
                    n_obp    = 1'b0;
                    n_ose    = r_toggle;
                    if (r_slot == IW'(PARAM_SLOTS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = r_slot + IW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_count  <= '0;
            r_toggle <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_count  <= n_count;
            r_toggle <= n_toggle;
            r_ovalid <= n_ovalid;
        end
        r_rd_addr <= n_rd_addr;
        r_slot    <= n_slot;
        r_word    <= n_word;
        r_oev     <= n_oev;
        r_oidx    <= n_oidx;
        r_oword   <= n_oword;
        r_olast   <= n_olast;
        r_ose     <= n_ose;
        r_orb     <= n_orb;
        r_obp     <= n_obp;
    end

    // Drive the master side
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_oev;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = TD_W'({r_obp, r_orb, r_ose, r_oword, r_oidx});

endmodule

`default_nettype wire

[rtl/core/ucpl_checker.sv]
// Port-level checks for the serial command and parameter loader.
// Depends on ucpl_pkg; bound to uart_command_parameter_loader below.
`default_nettype none

module ucpl_checker #(
    parameter int PARAM_SLOTS = ucpl_pkg::PARAM_SLOTS_DEF,
    localparam int IW         = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1,
    localparam int TD_W       = ((IW + 35 + 7) / 8) * 8
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [TD_W-1:0]               m_axis_tdata,
    input wire [ucpl_pkg::EVENT_W-1:0]  m_axis_tuser,
    input wire                          m_axis_tlast
);

    localparam int RB_BIT = IW + 33;
    localparam int BP_BIT = IW + 34;

    // Every result other than a parameter write ends its transaction group
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ucpl_pkg::EV_WRITE) |-> m_axis_tlast)
        else $error("non-write result without tlast");

    // Readback pulse only on a closing result
    a_rb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[RB_BIT] |-> m_axis_tlast)
        else $error("readback request away from tlast");

    // Beep only on command results
    a_beep_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[BP_BIT] |->
            (m_axis_tuser == ucpl_pkg::EV_CMD) || (m_axis_tuser == ucpl_pkg::EV_UNKNOWN))
        else $error("beep on a non-command result");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Take no input transaction while a result is stalled
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("input taken while a result is stalled");

endmodule

bind uart_command_parameter_loader ucpl_checker #(.PARAM_SLOTS(PARAM_SLOTS)) u_ucpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
